FILE: design/afhp_pkg.sv
package afhp_pkg;

    typedef enum logic [3:0] {
        PH_MAGIC, PH_FLAC, PH_RIFF_TYPE, PH_FORM_TYPE, PH_WAV_HDR, PH_WAV_FMT,
        PH_WAV_SKIP, PH_AIFF_HDR, PH_COMM, PH_COMM_SHORT, PH_AIFF_SKIP, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        CS_PARSE, CS_DIV, CS_OUT
    } t_ctl_state;

    localparam logic [1:0] FMT_UNKNOWN = 2'd0;
    localparam logic [1:0] FMT_FLAC    = 2'd1;
    localparam logic [1:0] FMT_WAVE    = 2'd2;
    localparam logic [1:0] FMT_AIFF    = 2'd3;

    localparam logic [31:0] TAG_FLAC = 32'h664C6143;
    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;
    localparam logic [31:0] TAG_FORM = 32'h464F524D;
    localparam logic [31:0] TAG_AIFF = 32'h41494646;
    localparam logic [31:0] TAG_AIFC = 32'h41494643;
    localparam logic [31:0] TAG_COMM = 32'h434F4D4D;

    localparam int EXP_BIAS = 16383 + 63;
    localparam int QUO_W    = 43;

    // controller -> datapath
    typedef struct packed {
        logic parse;     // byte accepted while parsing
        logic div_start;
        logic out_take;  // result word consumed
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic concluded; // this byte finishes the header or is the last byte
        logic div_done;
    } t_sts;

endpackage

FILE: design/afhp_ctrl.sv
module afhp_ctrl
    import afhp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_last,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_ctl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_PARSE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_PARSE: if (i_valid && i_sts.concluded) n_state = CS_DIV;
            CS_DIV:   if (i_sts.div_done) n_state = CS_OUT;
            CS_OUT:   if (i_out_ready) n_state = CS_PARSE;
            default:  n_state = CS_PARSE;
        endcase
    end

    always_comb begin
        o_ready     = (r_state == CS_PARSE);
        o_out_valid = (r_state == CS_OUT);
        o_cmd.parse     = (r_state == CS_PARSE) && i_valid;
        o_cmd.div_start = (r_state == CS_PARSE) && i_valid && i_sts.concluded;
        o_cmd.out_take  = (r_state == CS_OUT) && i_out_ready;
    end

    logic unused_last;
    assign unused_last = i_last;

endmodule

FILE: design/afhp_datapath.sv
module afhp_datapath
    import afhp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_byte,
    input  logic        i_eof,
    output t_sts        o_sts,
    output logic [1:0]  o_kind,
    output logic        o_ok,
    output logic [15:0] o_channels,
    output logic [31:0] o_rate,
    output logic [47:0] o_dur
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos;
    logic [1:0]  r_fmt, n_fmt;
    logic [63:0] r_recent;
    logic [32:0] r_skip, n_skip;
    logic [4:0]  r_off, n_off;
    logic [31:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [31:0] r_brate, n_brate;
    logic [35:0] r_len, n_len;
    logic [14:0] r_exp, n_exp;
    logic        n_emit;

    logic [63:0] w_r;
    logic [31:0] w_lo, w_id, w_swap;
    assign w_r    = {r_recent[55:0], i_byte};
    assign w_lo   = w_r[31:0];
    assign w_id   = w_r[63:32];
    assign w_swap = {w_lo[7:0], w_lo[15:8], w_lo[23:16], w_lo[31:24]};

    // extended rate: shift the 64-bit mantissa by the unbiased exponent
    function automatic logic [31:0] ext_rate(input logic [14:0] ex, input logic [63:0] m);
        logic signed [16:0] e;
        logic [6:0]  s;
        logic [64:0] q;
        logic [63:0] t;
        e = $signed({2'b00, ex}) - 17'(EXP_BIAS);
        ext_rate = '0;
        if (m == '0) begin
            ext_rate = '0;
        end else if (e >= 0) begin
            if (e >= 17'sd32) ext_rate = '1;
            else begin
                t = m << e[4:0];
                if ((m >> (6'd32 - {1'b0, e[4:0]})) != '0) ext_rate = '1;
                else ext_rate = t[31:0];
            end
        end else begin
            s = 7'(-e);
            if (-e > 17'sd64) ext_rate = '0;
            else if (s == 7'd64) ext_rate = {31'd0, m[63]};
            else begin
                t = m >> (s[5:0] - 6'd1);
                q = {1'b0, t >> 1} + {64'd0, t[0]};
                ext_rate = (q[64:32] != '0) ? '1 : q[31:0];
            end
        end
    endfunction

    always_comb begin
        n_phase = r_phase; n_fmt = r_fmt; n_skip = r_skip; n_off = r_off;
        n_chan = r_chan; n_rate = r_rate; n_brate = r_brate; n_len = r_len;
        n_exp = r_exp; n_emit = 1'b0;
        unique case (r_phase)
            PH_MAGIC: if (r_pos == 32'd3) begin
                if (w_lo == TAG_FLAC) begin n_fmt = FMT_FLAC; n_phase = PH_FLAC; end
                else if (w_lo == TAG_RIFF) n_phase = PH_RIFF_TYPE;
                else if (w_lo == TAG_FORM) n_phase = PH_FORM_TYPE;
                else n_emit = 1'b1;
            end
            PH_FLAC: if (r_pos == 32'd25) begin
                n_rate = {12'd0, w_r[63:44]};
                n_chan = {29'd0, w_r[43:41]} + 32'd1;
                n_len  = w_r[35:0];
                n_emit = 1'b1;
            end
            PH_RIFF_TYPE, PH_FORM_TYPE: if (r_pos == 32'd11) begin
                if (r_phase == PH_RIFF_TYPE && w_lo == TAG_WAVE) begin
                    n_fmt = FMT_WAVE; n_phase = PH_WAV_HDR; n_off = '0;
                end else if (r_phase == PH_FORM_TYPE &&
                             (w_lo == TAG_AIFF || w_lo == TAG_AIFC)) begin
                    n_fmt = FMT_AIFF; n_phase = PH_AIFF_HDR; n_off = '0;
                end else n_emit = 1'b1;
            end
            PH_WAV_HDR: if (r_off < 5'd7) n_off = r_off + 5'd1;
            else begin
                n_off = '0;
                if (w_id == TAG_DATA) begin
                    n_len = {4'd0, w_swap}; n_emit = 1'b1;
                end else if (w_id == TAG_FMT && w_swap >= 32'd16) begin
                    n_skip = {1'b0, w_swap} - 33'd16 + {32'd0, w_swap[0]};
                    n_phase = PH_WAV_FMT;
                end else if (({1'b0, w_swap} + {32'd0, w_swap[0]}) != '0) begin
                    n_skip = {1'b0, w_swap} + {32'd0, w_swap[0]};
                    n_phase = PH_WAV_SKIP;
                end
            end
            PH_WAV_FMT: begin
                if (r_off == 5'd3) n_chan = {16'd0, w_swap[31:16]};
                else if (r_off == 5'd7) n_rate = w_swap;
                else if (r_off == 5'd11) n_brate = w_swap;
                if (r_off < 5'd15) n_off = r_off + 5'd1;
                else begin
                    n_off = '0;
                    n_phase = (r_skip != '0) ? PH_WAV_SKIP : PH_WAV_HDR;
                end
            end
            PH_WAV_SKIP, PH_AIFF_SKIP, PH_COMM_SHORT: begin
                if (r_skip != '0) n_skip = r_skip - 33'd1;
                if (n_skip == '0) begin
                    n_off = '0;
                    if (r_phase == PH_WAV_SKIP) n_phase = PH_WAV_HDR;
                    else if (r_phase == PH_AIFF_SKIP) n_phase = PH_AIFF_HDR;
                    else n_emit = 1'b1;
                end
            end
            PH_AIFF_HDR: if (r_off < 5'd7) n_off = r_off + 5'd1;
            else begin
                n_off = '0;
                if (w_id == TAG_COMM) begin
                    if (w_lo >= 32'd18) n_phase = PH_COMM;
                    else if (w_lo == '0) n_emit = 1'b1;
                    else begin n_skip = {1'b0, w_lo}; n_phase = PH_COMM_SHORT; end
                end else if (({1'b0, w_lo} + {32'd0, w_lo[0]}) != '0) begin
                    n_skip = {1'b0, w_lo} + {32'd0, w_lo[0]};
                    n_phase = PH_AIFF_SKIP;
                end
            end
            PH_COMM: begin
                if (r_off == 5'd1) n_chan = {16'd0, w_lo[15:0]};
                else if (r_off == 5'd5) n_len = {4'd0, w_lo};
                else if (r_off == 5'd9) n_exp = w_lo[14:0];
                if (r_off < 5'd17) n_off = r_off + 5'd1;
                else begin
                    n_off = '0;
                    n_rate = ext_rate(r_exp, w_r);
                    n_emit = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // snapshot for the result, taken on the concluding word
    logic [1:0]  r_kind;
    logic [31:0] r_hchan, r_hrate;
    logic [31:0] r_div;
    logic [35:0] r_hlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC; r_pos <= '0; r_fmt <= '0; r_recent <= '0;
            r_skip <= '0; r_off <= '0; r_chan <= '0; r_rate <= '0;
            r_brate <= '0; r_len <= '0; r_exp <= '0;
        end else if (i_cmd.parse) begin
            if (i_eof) begin
                r_phase <= PH_MAGIC; r_pos <= '0; r_fmt <= '0; r_recent <= '0;
                r_skip <= '0; r_off <= '0; r_chan <= '0; r_rate <= '0;
                r_brate <= '0; r_len <= '0; r_exp <= '0;
            end else begin
                r_phase  <= n_emit ? PH_DONE : n_phase;
                r_pos    <= (r_pos == '1) ? r_pos : r_pos + 32'd1;
                r_fmt    <= n_fmt;   r_recent <= w_r;  r_skip <= n_skip;
                r_off    <= n_off;   r_chan   <= n_chan; r_rate <= n_rate;
                r_brate  <= n_brate; r_len    <= n_len;  r_exp  <= n_exp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_kind  <= n_fmt;
            r_hchan <= n_chan;
            r_hrate <= n_rate;
            r_hlen  <= n_len;
            r_div   <= (n_fmt == FMT_WAVE) ? n_brate : n_rate;
        end
    end

    // restoring divider, one quotient bit a cycle: len*100 (43 bits) / div
    logic [QUO_W-1:0] r_num, r_quo;
    logic [32:0]      r_rem;
    logic [5:0]       r_cnt;
    logic             r_busy, r_done;
    logic [33:0]      w_trial;
    assign w_trial = {r_rem, r_num[QUO_W-1]} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_busy <= 1'b1; r_cnt <= 6'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin r_busy <= 1'b0; r_done <= 1'b1; end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_num <= {7'd0, n_len} * 43'd100;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            if (!w_trial[33]) begin
                r_rem <= w_trial[32:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_num[QUO_W-1]};
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    // a file that already produced its result concludes nothing more
    assign o_sts = {(r_phase != PH_DONE) && (n_emit || i_eof), r_done};

    logic w_act;
    assign w_act = (r_kind != FMT_UNKNOWN) && (r_div != '0);
    assign o_kind     = r_kind;
    assign o_ok       = w_act && r_hlen != '0 && r_hchan != '0 && r_hrate != '0;
    assign o_channels = r_hchan[15:0];
    assign o_rate     = r_hrate;
    assign o_dur      = w_act ? r_quo[47-5:0] == r_quo ? {5'd0, r_quo} : '1 : '0;

    logic unused_take;
    assign unused_take = i_cmd.out_take;

endmodule

FILE: design/audio_file_header_parser.sv
// Audio file header parser. Feed the file one byte per word on the slave
// stream, tlast on the final byte. FLAC, RIFF/WAVE and FORM/AIFF(C) headers
// are recognized; exactly one result word per file is produced when the
// header concludes (or on the last byte). Bytes stream in at one per cycle;
// after the concluding byte the input stalls while a 43-step bit-serial
// divider forms the duration, and until the result word is taken. Later
// bytes of the file are accepted at one per cycle.
module audio_file_header_parser
    import afhp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // end_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] format_kind, [2] header_ok, [18:3] channel_count,
    // [50:19] sample_rate, [98:51] duration_centis, [103:99] zero
    output logic [103:0] m_axis_tdata
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic [1:0]  w_kind;
    logic        w_ok;
    logic [15:0] w_ch;
    logic [31:0] w_rate;
    logic [47:0] w_dur;
    logic        w_ready;

    afhp_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .i_last(s_axis_tlast),
        .i_out_ready(m_axis_tready), .i_sts(w_sts),
        .o_ready(w_ready), .o_out_valid(m_axis_tvalid), .o_cmd(w_cmd)
    );

    afhp_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd),
        .i_byte(s_axis_tdata), .i_eof(s_axis_tlast), .o_sts(w_sts),
        .o_kind(w_kind), .o_ok(w_ok), .o_channels(w_ch), .o_rate(w_rate),
        .o_dur(w_dur)
    );

    assign s_axis_tready = w_ready;
    assign m_axis_tdata  = {5'd0, w_dur, w_rate, w_ch, w_ok, w_kind};

endmodule

FILE: design/afhp_checker.sv
module afhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [103:0] m_axis_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input taken while result pending");

    a_unk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == 2'd0 |-> m_axis_tdata[98:2] == '0)
        else $error("unknown format carries fields");

    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |->
            m_axis_tdata[18:3] != '0 && m_axis_tdata[50:19] != '0)
        else $error("header_ok with zero channels or rate");

    logic unused_v;
    assign unused_v = s_axis_tvalid;

endmodule

bind audio_file_header_parser afhp_checker u_chk (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
